// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds -> post holds in the same cycle
`define IKPC_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// pre holds -> post holds in the next cycle
`define IKPC_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/ikpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ikpc_pkg
// Types and constants shared by the interval point cover block.
// ----------------------------------------------------------------------------
package ikpc_pkg;

  localparam int COORD_W  = 15;
  localparam int TOT_W    = 16;
  localparam int OFF_CAP  = 32768;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [COORD_W-1:0] BIAS_FLIP = 15'h4000;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic REG_NEED_COUNT = 1'b0;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SORT_INIT, S_I_RD, S_I_KEY, S_J_RD, S_J_CMP, S_PLACE,
    S_WALK_INIT, S_K_RD, S_K_LD, S_P_RD, S_P_CHK, S_FINISH, S_R_RD, S_R_CHK
  } state_t;

  typedef enum logic [1:0] {
    PH_SHORT, PH_COUNT, PH_DOWN
  } phase_t;

  typedef struct packed {
    logic take;
    logic clr_step;
    logic emit_load;
    logic sort_init;
    logic i_rd;
    logic key_ld;
    logic j_rd;
    logic shift;
    logic place;
    logic walk_init;
    logic iv_ld;
    logic p_rd;
    logic p_chk;
    logic finish;
    logic r_chk;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic go_clear;
    logic go_sort;
    logic go_scan;
    logic pend_last;
    logic clr_done;
    logic i_done;
    logic j_zero;
    logic hi_greater;
    logic k_done;
    logic iv_end;
    logic found;
  } stat_t;

endpackage

// ===== hw/rtl/ikpc_ram.sv =====
// ----------------------------------------------------------------------------
// ikpc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ikpc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ikpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ikpc_ctrl
// Sequencer: item intake, map clear, insertion sort, greedy walk, readout.
// ----------------------------------------------------------------------------
module ikpc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  ikpc_pkg::stat_t  st,
  output ikpc_pkg::cmd_t   cmd
);

  ikpc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ikpc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ikpc_pkg::S_IDLE: begin
        item_stall = !st.out_free;
        if (item_valid && st.out_free) begin
          cmd.take = 1'b1;
          priority if (st.go_clear) begin
            state_next = ikpc_pkg::S_CLEAR;
          end else if (st.go_sort) begin
            state_next = ikpc_pkg::S_SORT_INIT;
          end else if (st.go_scan) begin
            state_next = ikpc_pkg::S_R_RD;
          end else begin
            state_next = ikpc_pkg::S_IDLE;
          end
        end
      end
      ikpc_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) begin
          if (st.pend_last) begin
            state_next = ikpc_pkg::S_SORT_INIT;
          end else begin
            cmd.emit_load = 1'b1;
            state_next    = ikpc_pkg::S_IDLE;
          end
        end
      end
      ikpc_pkg::S_SORT_INIT: begin
        cmd.sort_init = 1'b1;
        state_next    = ikpc_pkg::S_I_RD;
      end
      ikpc_pkg::S_I_RD: begin
        if (st.i_done) begin
          state_next = ikpc_pkg::S_WALK_INIT;
        end else begin
          cmd.i_rd   = 1'b1;
          state_next = ikpc_pkg::S_I_KEY;
        end
      end
      ikpc_pkg::S_I_KEY: begin
        cmd.key_ld = 1'b1;
        state_next = ikpc_pkg::S_J_RD;
      end
      ikpc_pkg::S_J_RD: begin
        if (st.j_zero) begin
          state_next = ikpc_pkg::S_PLACE;
        end else begin
          cmd.j_rd   = 1'b1;
          state_next = ikpc_pkg::S_J_CMP;
        end
      end
      ikpc_pkg::S_J_CMP: begin
        if (st.hi_greater) begin
          cmd.shift  = 1'b1;
          state_next = ikpc_pkg::S_J_RD;
        end else begin
          state_next = ikpc_pkg::S_PLACE;
        end
      end
      ikpc_pkg::S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = ikpc_pkg::S_I_RD;
      end
      ikpc_pkg::S_WALK_INIT: begin
        cmd.walk_init = 1'b1;
        state_next    = ikpc_pkg::S_K_RD;
      end
      ikpc_pkg::S_K_RD: begin
        if (st.k_done) begin
          state_next = ikpc_pkg::S_FINISH;
        end else begin
          state_next = ikpc_pkg::S_K_LD;
        end
      end
      ikpc_pkg::S_K_LD: begin
        cmd.iv_ld  = 1'b1;
        state_next = ikpc_pkg::S_P_RD;
      end
      ikpc_pkg::S_P_RD: begin
        cmd.p_rd   = 1'b1;
        state_next = ikpc_pkg::S_P_CHK;
      end
      ikpc_pkg::S_P_CHK: begin
        cmd.p_chk  = 1'b1;
        state_next = st.iv_end ? ikpc_pkg::S_K_RD : ikpc_pkg::S_P_RD;
      end
      ikpc_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ikpc_pkg::S_IDLE;
      end
      ikpc_pkg::S_R_RD: begin
        state_next = ikpc_pkg::S_R_CHK;
      end
      ikpc_pkg::S_R_CHK: begin
        cmd.r_chk  = 1'b1;
        state_next = st.found ? ikpc_pkg::S_IDLE : ikpc_pkg::S_R_RD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ikpc_dp.sv =====
// ----------------------------------------------------------------------------
// ikpc_dp
// Datapath: interval store, position map, counters, config and result regs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ikpc_dp #(
  parameter int MAX_INTERVALS = 1024,
  parameter int POS_SPAN      = 32768
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ikpc_pkg::cmd_t                cmd,
  output ikpc_pkg::stat_t               st,
  input  logic                          mode,
  input  logic signed [ikpc_pkg::COORD_W-1:0] end_a,
  input  logic signed [ikpc_pkg::COORD_W-1:0] end_b,
  input  logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ikpc_pkg::APB_AW-1:0]   paddr,
  input  logic [ikpc_pkg::APB_DW-1:0]   pwdata,
  output logic [ikpc_pkg::APB_DW-1:0]   prdata,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [ikpc_pkg::COORD_W-1:0] position,
  output logic [ikpc_pkg::TOT_W-1:0]    total,
  output logic                          final_point,
  output logic [1:0]                    status
);

  localparam int CRW       = ikpc_pkg::COORD_W;
  localparam int TW        = ikpc_pkg::TOT_W;
  localparam int MAP_DEPTH = (POS_SPAN < ikpc_pkg::OFF_CAP) ? POS_SPAN : ikpc_pkg::OFF_CAP;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int IAW       = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW        = $clog2(MAX_INTERVALS + 1);
  localparam int SW        = 2 * CRW;

  logic [TW-1:0]  need, tot, cursor, rd_count, have, want;
  logic           set_open, map_valid, drop, pend_last;
  logic [CW-1:0]  count, i, j, k;
  logic [CRW-1:0] key_lo, key_hi, lo, hi, o;
  ikpc_pkg::phase_t phase;
  logic [MAP_AW-1:0] clr_addr;

  logic           res_valid, res_final;
  logic [CRW-1:0] res_pos;
  logic [TW-1:0]  res_total;
  logic [1:0]     res_status;

  logic [CRW-1:0] off_a, off_b, in_lo, in_hi, q_lo, q_hi;
  logic           is_load, full, exhausted, cfg_wr;
  logic [CW-1:0]  cnt_base, cnt_next, jm1;
  logic [SW-1:0]  store_q, store_wdata;
  logic           store_we;
  logic [IAW-1:0] store_waddr, store_raddr;
  logic           map_q, map_we, map_wdata;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic           in_range, hit, mark_ok, iv_end, take_emit, emit;
  logic [TW-1:0]  have_n, want_calc, want_n, len;

  assign off_a   = end_a ^ ikpc_pkg::BIAS_FLIP;
  assign off_b   = end_b ^ ikpc_pkg::BIAS_FLIP;
  assign in_lo   = (off_a < off_b) ? off_a : off_b;
  assign in_hi   = (off_a < off_b) ? off_b : off_a;
  assign is_load = (mode == ikpc_pkg::MODE_LOAD);

  assign cnt_base  = set_open ? count : '0;
  assign full      = (cnt_base >= CW'(MAX_INTERVALS));
  assign cnt_next  = full ? cnt_base : cnt_base + 1'b1;
  assign exhausted = !map_valid || (rd_count == tot);
  assign jm1       = j - 1'b1;

  assign q_lo = store_q[CRW-1:0];
  assign q_hi = store_q[SW-1:CRW];

  assign in_range  = ({1'b0, o} < TW'(MAP_DEPTH));
  assign hit       = in_range && map_q;
  assign mark_ok   = in_range && !map_q;
  assign have_n    = have + TW'(hit);
  assign want_calc = (have_n < need) ? need - have_n : '0;
  assign want_n    = want - TW'(mark_ok);
  assign len       = TW'({1'b0, q_hi}) - TW'({1'b0, q_lo}) + TW'(1);

  always_comb begin
    unique case (phase)
      ikpc_pkg::PH_SHORT: iv_end = (o == hi);
      ikpc_pkg::PH_COUNT: iv_end = (o == hi) && (want_calc == '0);
      ikpc_pkg::PH_DOWN:  iv_end = (want_n == '0) || (o == lo);
      default:            iv_end = 1'b1;
    endcase
  end

  assign take_emit = cmd.take && ((is_load && set_open && !last) || (!is_load && exhausted));
  assign emit      = take_emit || cmd.emit_load || cmd.finish || (cmd.r_chk && map_q);

  assign st.out_free   = !res_valid || !result_stall;
  assign st.go_clear   = is_load && !set_open;
  assign st.go_sort    = is_load && set_open && last;
  assign st.go_scan    = !is_load && !exhausted;
  assign st.pend_last  = pend_last;
  assign st.clr_done   = (clr_addr == MAP_AW'(MAP_DEPTH - 1));
  assign st.i_done     = (i >= count);
  assign st.j_zero     = (j == '0);
  assign st.hi_greater = (q_hi > key_hi);
  assign st.k_done     = (k >= count);
  assign st.iv_end     = iv_end;
  assign st.found      = map_q;

  // interval store: {hi, lo} offsets
  assign store_we    = (cmd.take && is_load && !full) || cmd.shift || cmd.place;
  assign store_waddr = cmd.take ? cnt_base[IAW-1:0] : j[IAW-1:0];
  assign store_wdata = cmd.take ? {in_hi, in_lo} : (cmd.shift ? store_q : {key_hi, key_lo});
  assign store_raddr = cmd.i_rd ? i[IAW-1:0] : (cmd.j_rd ? jm1[IAW-1:0] : k[IAW-1:0]);

  assign map_we    = cmd.clr_step || (cmd.p_chk && mark_ok && (phase != ikpc_pkg::PH_COUNT));
  assign map_waddr = cmd.clr_step ? clr_addr : o[MAP_AW-1:0];
  assign map_wdata = !cmd.clr_step;
  assign map_raddr = cmd.p_rd ? o[MAP_AW-1:0] : cursor[MAP_AW-1:0];

  ikpc_ram #(.WIDTH(SW), .DEPTH(MAX_INTERVALS), .ADDR_W(IAW)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_q)
  );

  ikpc_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH), .ADDR_W(MAP_AW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ikpc_pkg::REG_NEED_COUNT);
  assign prdata = (paddr[2] == ikpc_pkg::REG_NEED_COUNT) ? ikpc_pkg::APB_DW'(need) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      need      <= TW'(1);
      set_open  <= 1'b0;
      map_valid <= 1'b0;
      count     <= '0;
      tot       <= '0;
      cursor    <= '0;
      rd_count  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        need <= pwdata[TW-1:0];
      end
      if (cmd.take && is_load) begin
        count <= cnt_next;
        if (!set_open) begin
          set_open  <= 1'b1;
          map_valid <= 1'b0;
          tot       <= '0;
          cursor    <= '0;
          rd_count  <= '0;
        end
      end
      if (map_we && !cmd.clr_step) begin
        tot <= tot + TW'(1);
      end
      if (cmd.finish) begin
        set_open  <= 1'b0;
        map_valid <= 1'b1;
      end
      if (cmd.r_chk) begin
        cursor <= cursor + TW'(1);
        if (map_q) begin
          rd_count <= rd_count + TW'(1);
        end
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!result_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && is_load) begin
      drop      <= full;
      pend_last <= last;
      clr_addr  <= '0;
    end
    if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
    if (cmd.sort_init) begin
      i <= CW'(1);
    end
    if (cmd.key_ld) begin
      key_lo <= q_lo;
      key_hi <= q_hi;
      j      <= i;
    end
    if (cmd.shift) begin
      j <= jm1;
    end
    if (cmd.place) begin
      i <= i + 1'b1;
    end
    if (cmd.walk_init) begin
      k <= '0;
    end
    if (cmd.iv_ld) begin
      lo    <= q_lo;
      hi    <= q_hi;
      o     <= q_lo;
      have  <= '0;
      phase <= (len > need) ? ikpc_pkg::PH_COUNT : ikpc_pkg::PH_SHORT;
    end
    if (cmd.p_chk) begin
      unique case (phase)
        ikpc_pkg::PH_SHORT: begin
          if (!iv_end) o <= o + 1'b1;
        end
        ikpc_pkg::PH_COUNT: begin
          have <= have_n;
          if (o == hi) begin
            want  <= want_calc;
            phase <= ikpc_pkg::PH_DOWN;
          end else begin
            o <= o + 1'b1;
          end
        end
        ikpc_pkg::PH_DOWN: begin
          want <= want_n;
          if (o != lo) o <= o - 1'b1;
        end
        default: phase <= ikpc_pkg::PH_SHORT;
      endcase
      if (iv_end) begin
        k <= k + 1'b1;
      end
    end

    priority if (take_emit) begin
      res_pos    <= '0;
      res_final  <= 1'b0;
      res_total  <= is_load ? TW'(cnt_next) : tot;
      res_status <= is_load ? (full ? ikpc_pkg::ST_FULL : ikpc_pkg::ST_OK)
                            : ikpc_pkg::ST_EMPTY;
    end else if (cmd.emit_load || cmd.finish) begin
      res_pos    <= '0;
      res_final  <= 1'b0;
      res_total  <= cmd.finish ? tot : TW'(count);
      res_status <= drop ? ikpc_pkg::ST_FULL : ikpc_pkg::ST_OK;
    end else if (cmd.r_chk && map_q) begin
      res_pos    <= cursor[CRW-1:0] ^ ikpc_pkg::BIAS_FLIP;
      res_final  <= ((rd_count + TW'(1)) == tot);
      res_total  <= tot;
      res_status <= ikpc_pkg::ST_OK;
    end
  end

  assign result_valid = res_valid;
  assign position     = res_pos;
  assign total        = res_total;
  assign final_point  = res_final;
  assign status       = res_status;

  `IKPC_ASSERT_IMP(a_take_free, cmd.take, (!res_valid || !result_stall), "item taken while result held")
  `IKPC_ASSERT_IMP(a_rd_le_tot, 1'b1, (rd_count <= tot), "readout count passed total")
  `IKPC_ASSERT_IMP(a_count_cap, 1'b1, (count <= CW'(MAX_INTERVALS)), "interval count over capacity")
  `IKPC_ASSERT_IMP(a_scan_valid, cmd.r_chk, (map_valid && in_range || map_valid), "scan without valid map")
  `IKPC_ASSERT_NXT(a_finish, cmd.finish, (map_valid && !set_open && res_valid), "finish did not close set")

endmodule

// ===== hw/rtl/interval_k_point_cover.sv =====
// ----------------------------------------------------------------------------
// interval_k_point_cover
// Greedy choice of positions so that each loaded interval holds need_count, or all its positions when shorter.
//
//   channel   signals                                   direction
//   item      item_valid/item_stall, mode/end_a/end_b/last   in
//   result    result_valid/result_stall, position/total/final_point/status out
//   config    psel/penable/pwrite/paddr/pwdata/prdata/pready   APB
//
// The first load of a set adds a map clear of POS_SPAN words (capped at
// 32768), one map word per cycle. A final load adds the insertion sort (each
// compare reads through the single store read port) and the greedy walk over
// the map positions of each interval. A readout scans map positions from the
// cursor up to the next marked one. rst is synchronous; the result register
// holds while result_stall is high.
// ----------------------------------------------------------------------------
module interval_k_point_cover #(
  parameter int MAX_INTERVALS = 1024,
  parameter int POS_SPAN      = 32768
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        mode,
  input  logic signed [ikpc_pkg::COORD_W-1:0] end_a,
  input  logic signed [ikpc_pkg::COORD_W-1:0] end_b,
  input  logic                        last,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [ikpc_pkg::COORD_W-1:0] position,
  output logic [ikpc_pkg::TOT_W-1:0]  total,
  output logic                        final_point,
  output logic [1:0]                  status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ikpc_pkg::APB_AW-1:0] paddr,
  input  logic [ikpc_pkg::APB_DW-1:0] pwdata,
  output logic [ikpc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  ikpc_pkg::cmd_t  cmd;
  ikpc_pkg::stat_t st;

  assign pready = 1'b1;

  ikpc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  ikpc_dp #(.MAX_INTERVALS(MAX_INTERVALS), .POS_SPAN(POS_SPAN)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .mode         (mode),
    .end_a        (end_a),
    .end_b        (end_b),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .position     (position),
    .total        (total),
    .final_point  (final_point),
    .status       (status)
  );

endmodule

// ===== tb/sv/tb_interval_k_point_cover.sv =====
// ----------------------------------------------------------------------------
// tb_interval_k_point_cover
// Self-checking bench for the greedy interval point cover block. A queue of
// load and readout transfers feeds a clocked driver. A built-in predictor
// keeps its own interval store, position map and need_count. Every accepted
// result is compared field by field with the oldest prediction. Sender and
// receiver idle at random in several phases. need_count is changed over APB
// between sets, extremes included.
// ----------------------------------------------------------------------------
module tb_interval_k_point_cover;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 1024;
  localparam int MAP_SPAN    = 32768;
  localparam int BIAS        = 16384;

  typedef struct {
    logic                                mode;
    logic signed [ikpc_pkg::COORD_W-1:0] a;
    logic signed [ikpc_pkg::COORD_W-1:0] b;
    logic                                last;
  } cover_item_t;

  typedef struct {
    logic signed [ikpc_pkg::COORD_W-1:0] position;
    logic [ikpc_pkg::TOT_W-1:0]          total;
    logic                                final_point;
    logic [1:0]                          status;
  } cover_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic mode = ikpc_pkg::MODE_LOAD;
  logic signed [ikpc_pkg::COORD_W-1:0] end_a = '0;
  logic signed [ikpc_pkg::COORD_W-1:0] end_b = '0;
  logic last = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [ikpc_pkg::COORD_W-1:0] position;
  logic [ikpc_pkg::TOT_W-1:0] total;
  logic final_point;
  logic [1:0] status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ikpc_pkg::APB_AW-1:0] paddr = '0;
  logic [ikpc_pkg::APB_DW-1:0] pwdata = '0;
  logic [ikpc_pkg::APB_DW-1:0] prdata;
  logic pready;

  interval_k_point_cover uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  int          iv_lo [STORE_DEPTH];
  int          iv_hi [STORE_DEPTH];
  bit          marked [MAP_SPAN];
  int unsigned iv_count;
  int unsigned point_total;
  int unsigned read_cursor;
  bit          set_open;
  int unsigned need;

  cover_item_t   pending_q[$];
  cover_result_t expected_q[$];
  int unsigned   n_issued;
  int unsigned   n_checked;
  int unsigned   n_errors;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;

  function automatic void mark_pos(int o);
    if (o >= 0 && o < MAP_SPAN && !marked[o]) begin
      marked[o] = 1'b1;
      point_total++;
    end
  endfunction

  function automatic void place_points();
    int j;
    int lo;
    int hi;
    int unsigned have;
    int unsigned want;
    for (int i = 1; i < iv_count; i++) begin
      lo = iv_lo[i];
      hi = iv_hi[i];
      j = i;
      while (j > 0 && iv_hi[j-1] > hi) begin
        iv_lo[j] = iv_lo[j-1];
        iv_hi[j] = iv_hi[j-1];
        j--;
      end
      iv_lo[j] = lo;
      iv_hi[j] = hi;
    end
    for (int i = 0; i < iv_count; i++) begin
      lo = iv_lo[i];
      hi = iv_hi[i];
      if (hi - lo + 1 <= need) begin
        for (int o = lo; o <= hi; o++) mark_pos(o);
      end else begin
        have = 0;
        for (int o = lo; o <= hi; o++) if (marked[o]) have++;
        want = (have < need) ? need - have : 0;
        for (int o = hi; o >= lo && want > 0; o--) begin
          if (!marked[o]) begin
            mark_pos(o);
            want--;
          end
        end
      end
    end
    read_cursor = 0;
    set_open = 1'b0;
  endfunction

  function automatic cover_result_t predict_cover(cover_item_t it);
    cover_result_t r;
    int oa;
    int ob;
    int o;
    int n;
    r = '{position: '0, total: '0, final_point: 1'b0, status: ikpc_pkg::ST_OK};
    if (it.mode == ikpc_pkg::MODE_LOAD) begin
      oa = int'(it.a) + BIAS;
      ob = int'(it.b) + BIAS;
      if (!set_open) begin
        foreach (marked[k]) marked[k] = 1'b0;
        iv_count = 0;
        point_total = 0;
        read_cursor = 0;
        set_open = 1'b1;
      end
      if (iv_count >= STORE_DEPTH) begin
        r.status = ikpc_pkg::ST_FULL;
      end else begin
        iv_lo[iv_count] = (oa < ob) ? oa : ob;
        iv_hi[iv_count] = (oa < ob) ? ob : oa;
        iv_count++;
      end
      if (it.last) begin
        place_points();
        r.total = ikpc_pkg::TOT_W'(point_total);
      end else begin
        r.total = ikpc_pkg::TOT_W'(iv_count);
      end
    end else begin
      r.total = ikpc_pkg::TOT_W'(point_total);
      o = read_cursor;
      while (o < MAP_SPAN && !marked[o]) o++;
      if (o < MAP_SPAN) begin
        r.position = ikpc_pkg::COORD_W'(o - BIAS);
        read_cursor = o + 1;
        n = o + 1;
        while (n < MAP_SPAN && !marked[n]) n++;
        r.final_point = (n >= MAP_SPAN);
      end else begin
        r.status = ikpc_pkg::ST_EMPTY;
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    cover_item_t nx;
    if (rst) begin
      item_valid <= 1'b0;
      result_stall <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        nx = '{mode: mode, a: end_a, b: end_b, last: last};
        expected_q.push_back(predict_cover(nx));
      end
      if (!item_valid || !item_stall) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nx = pending_q.pop_front();
          item_valid <= 1'b1;
          mode <= nx.mode;
          end_a <= nx.a;
          end_b <= nx.b;
          last <= nx.last;
        end else begin
          item_valid <= 1'b0;
        end
      end
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cover_result_t e;
    if (!rst && result_valid && !result_stall) begin
      n_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (position !== e.position) begin
          $error("position exp %0d got %0d", e.position, position);
          n_errors++;
        end
        if (total !== e.total) begin
          $error("total exp %0d got %0d", e.total, total);
          n_errors++;
        end
        if (final_point !== e.final_point) begin
          $error("final_point exp %0d got %0d", e.final_point, final_point);
          n_errors++;
        end
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status);
          n_errors++;
        end
      end
    end
  end

  task automatic push_item(logic m, int a, int b, logic l);
    pending_q.push_back('{mode: m, a: ikpc_pkg::COORD_W'(a), b: ikpc_pkg::COORD_W'(b),
                          last: l});
    n_issued++;
  endtask

  task automatic write_need(int unsigned v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ikpc_pkg::APB_AW'(4 * ikpc_pkg::REG_NEED_COUNT);
    pwdata <= ikpc_pkg::APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    need = v & 16'hFFFF;
  endtask

  task automatic drain();
    while (n_checked < n_issued) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_phase(int p);
    case (p % 4)
      0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      1: begin send_idle_pct = 78; recv_idle_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_idle_pct = 78; end
      default: begin send_idle_pct = 19; recv_idle_pct = 19; end
    endcase
  endtask

  // loads clustered near the low end keep map scans short
  task automatic random_set(int n_iv, int spread, int max_len);
    int a;
    int b;
    for (int i = 0; i < n_iv; i++) begin
      if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 32767) - BIAS;
      else a = $urandom_range(0, spread) - BIAS;
      b = a + $urandom_range(0, max_len);
      if (b > 16383) b = 16383;
      if ($urandom_range(0, 1)) push_item(ikpc_pkg::MODE_LOAD, b, a, i == n_iv - 1);
      else push_item(ikpc_pkg::MODE_LOAD, a, b, i == n_iv - 1);
    end
    for (int i = $urandom_range(5, 25); i > 0; i--)
      push_item(ikpc_pkg::MODE_READ, $urandom_range(0, 32767), $urandom_range(0, 32767),
                $urandom_range(0, 1));
  endtask

  initial begin
    int unsigned need_vals[6];
    iv_count = 0;
    point_total = 0;
    read_cursor = 0;
    set_open = 1'b0;
    need = 1;
    n_issued = 0;
    n_checked = 0;
    n_errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (marked[k]) marked[k] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: readout before any set, reversed ends, extremes, ties,
    // readout while open, full-range interval, readout to exhaustion
    push_item(ikpc_pkg::MODE_READ, 0, 0, 1'b0);
    push_item(ikpc_pkg::MODE_LOAD, 5, -3, 1'b0);
    push_item(ikpc_pkg::MODE_LOAD, -16384, -16380, 1'b0);
    push_item(ikpc_pkg::MODE_READ, -1, -1, 1'b1);
    push_item(ikpc_pkg::MODE_LOAD, 16383, 16383, 1'b0);
    push_item(ikpc_pkg::MODE_LOAD, 2, 5, 1'b0);
    push_item(ikpc_pkg::MODE_LOAD, 5, 4, 1'b0);
    push_item(ikpc_pkg::MODE_LOAD, -16384, -16384, 1'b0);
    push_item(ikpc_pkg::MODE_LOAD, 0, 0, 1'b0);
    push_item(ikpc_pkg::MODE_LOAD, 16383, -16384, 1'b1);
    for (int i = 0; i < 9; i++) push_item(ikpc_pkg::MODE_READ, -16384, 16383, i[0]);
    drain();

    need_vals = '{32768, 0, 1, 65535, 2, 5};
    for (int s = 0; s < 14; s++) begin
      set_phase(s);
      write_need(s < 6 ? need_vals[s] : $urandom_range(1, 40));
      random_set($urandom_range(20, 60), $urandom_range(40, 400),
                 (need > 64 && s % 2 == 0) ? 8 : $urandom_range(4, 60));
      drain();
    end

    // fill the store past capacity; the final load is dropped too
    set_phase(3);
    write_need(3);
    for (int i = 0; i < STORE_DEPTH + 2; i++)
      push_item(ikpc_pkg::MODE_LOAD, -BIAS + i, -BIAS + i + (i % 4),
                i == STORE_DEPTH + 1);
    for (int i = 0; i < 12; i++) push_item(ikpc_pkg::MODE_READ, i, -i, 1'b0);
    drain();

    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
